/* hdl/bgc_pkg.sv */
// Shared types and codes for the block glyph classifier.
package bgc_pkg;

	// Glyph codes as delivered on the result channel
	typedef enum logic [3:0] {
		GLYPH_SPACE  = 4'd0,
		GLYPH_LIGHT  = 4'd1,
		GLYPH_MEDIUM = 4'd2,
		GLYPH_DARK   = 4'd3,
		GLYPH_FULL   = 4'd4,
		GLYPH_UPPER  = 4'd5,
		GLYPH_LOWER  = 4'd6,
		GLYPH_Q_UL   = 4'd7,
		GLYPH_Q_UR   = 4'd8,
		GLYPH_Q_LL   = 4'd9,
		GLYPH_Q_LR   = 4'd10,
		GLYPH_LEFT   = 4'd11,
		GLYPH_RIGHT  = 4'd12
	} glyph_t;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_QUARTER_EN = 2'd0,
		CFG_HALF_EN    = 2'd1
	} cfg_reg_t;

	// Quadrant order inside the high-flag vector
	localparam int QD_TL = 3;
	localparam int QD_TR = 2;
	localparam int QD_BL = 1;
	localparam int QD_BR = 0;

	// Decision inputs handed from the threshold stage to the select stage
	typedef struct packed {
		logic [3:0] high;         // quadrant above the four-quadrant average
		logic       quarter_ok;   // quarter mode enabled and TL contrast met
		logic       half_tie;     // top and bottom within the tie band
		logic       top_brighter; // top sum above bottom sum
		glyph_t     shade_sum;    // shade of the four-quadrant average
		glyph_t     shade_mean;   // shade of the cell mean
	} bgc_s2_t;

endpackage

/* hdl/bgc_front.sv */
// Stage 1: quadrant differences, sums and high flags.
module bgc_front #(
	parameter int LUM_BITS = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [LUM_BITS-1:0] lum_top_left,
	input  logic [LUM_BITS-1:0] lum_top_right,
	input  logic [LUM_BITS-1:0] lum_bottom_left,
	input  logic [LUM_BITS-1:0] lum_bottom_right,
	input  logic [LUM_BITS-1:0] lum_cell_mean,
	output logic                v_s1,
	output logic [LUM_BITS-1:0] dtr_s1,
	output logic [LUM_BITS-1:0] dbl_s1,
	output logic [LUM_BITS:0]   top_s1,
	output logic [LUM_BITS:0]   bot_s1,
	output logic [LUM_BITS+1:0] sum_s1,
	output logic [3:0]          high_s1,
	output logic [LUM_BITS-1:0] mean_s1
);
	import bgc_pkg::*;

	logic [LUM_BITS-1:0] dtr;
	logic [LUM_BITS-1:0] dbl;
	logic [LUM_BITS:0]   top;
	logic [LUM_BITS:0]   bot;
	logic [LUM_BITS+1:0] sum;
	logic [3:0]          high;

	// TL contrast against its neighbors
	assign dtr = (lum_top_left > lum_top_right) ? lum_top_left - lum_top_right
	                                            : lum_top_right - lum_top_left;
	assign dbl = (lum_top_left > lum_bottom_left) ? lum_top_left - lum_bottom_left
	                                              : lum_bottom_left - lum_top_left;

	// Row sums and total
	assign top = {1'b0, lum_top_left} + {1'b0, lum_top_right};
	assign bot = {1'b0, lum_bottom_left} + {1'b0, lum_bottom_right};
	assign sum = {1'b0, top} + {1'b0, bot};

	// 4*q > sum, exact
	assign high[QD_TL] = {lum_top_left, 2'b00} > sum;
	assign high[QD_TR] = {lum_top_right, 2'b00} > sum;
	assign high[QD_BL] = {lum_bottom_left, 2'b00} > sum;
	assign high[QD_BR] = {lum_bottom_right, 2'b00} > sum;

	// Valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			dtr_s1  <= dtr;
			dbl_s1  <= dbl;
			top_s1  <= top;
			bot_s1  <= bot;
			sum_s1  <= sum;
			high_s1 <= high;
			mean_s1 <= lum_cell_mean;
		end
	end

endmodule

/* hdl/bgc_thresh.sv */
// Stage 2: contrast, tie band and shade threshold compares.
module bgc_thresh #(
	parameter int LUM_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  quarter_en,
	input  logic                  v_s1,
	input  logic [LUM_BITS-1:0]   dtr_s1,
	input  logic [LUM_BITS-1:0]   dbl_s1,
	input  logic [LUM_BITS:0]     top_s1,
	input  logic [LUM_BITS:0]     bot_s1,
	input  logic [LUM_BITS+1:0]   sum_s1,
	input  logic [3:0]            high_s1,
	input  logic [LUM_BITS-1:0]   mean_s1,
	output logic                  v_s2,
	output bgc_pkg::bgc_s2_t      ctl_s2
);
	import bgc_pkg::*;

	// 1.0 in the widths of the scaled differences
	localparam logic [LUM_BITS+3:0] ONE_Q = {4'b0001, {LUM_BITS{1'b0}}};
	localparam logic [LUM_BITS+4:0] ONE_H = {5'b00001, {LUM_BITS{1'b0}}};
	// Shade bounds k/16 for the four-quadrant sum (scale 4.0)
	localparam logic [LUM_BITS+1:0] SUM_T1  = {4'b0001, {(LUM_BITS-2){1'b0}}};
	localparam logic [LUM_BITS+1:0] SUM_T3  = {4'b0011, {(LUM_BITS-2){1'b0}}};
	localparam logic [LUM_BITS+1:0] SUM_T7  = {4'b0111, {(LUM_BITS-2){1'b0}}};
	localparam logic [LUM_BITS+1:0] SUM_T11 = {4'b1011, {(LUM_BITS-2){1'b0}}};
	// Shade bounds k/16 for the cell mean (scale 1.0)
	localparam logic [LUM_BITS-1:0] MEAN_T1  = {4'b0001, {(LUM_BITS-4){1'b0}}};
	localparam logic [LUM_BITS-1:0] MEAN_T3  = {4'b0011, {(LUM_BITS-4){1'b0}}};
	localparam logic [LUM_BITS-1:0] MEAN_T7  = {4'b0111, {(LUM_BITS-4){1'b0}}};
	localparam logic [LUM_BITS-1:0] MEAN_T11 = {4'b1011, {(LUM_BITS-4){1'b0}}};

	// below = {< 1/16, < 3/16, < 7/16, < 11/16}
	function automatic glyph_t shade_code(input logic [3:0] below);
		glyph_t g;
		if (below[3]) begin
			g = GLYPH_SPACE;
		end else if (below[2]) begin
			g = GLYPH_LIGHT;
		end else if (below[1]) begin
			g = GLYPH_MEDIUM;
		end else if (below[0]) begin
			g = GLYPH_DARK;
		end else begin
			g = GLYPH_FULL;
		end
		return g;
	endfunction

	logic [LUM_BITS+3:0] dtr_x10;
	logic [LUM_BITS+3:0] dbl_x10;
	logic [LUM_BITS:0]   dh;
	logic [LUM_BITS+4:0] dh_x10;
	bgc_s2_t             ctl;

	// 10*d as 8*d + 2*d
	assign dtr_x10 = {1'b0, dtr_s1, 3'b000} + {3'b000, dtr_s1, 1'b0};
	assign dbl_x10 = {1'b0, dbl_s1, 3'b000} + {3'b000, dbl_s1, 1'b0};
	assign dh      = (top_s1 > bot_s1) ? top_s1 - bot_s1 : bot_s1 - top_s1;
	assign dh_x10  = {1'b0, dh, 3'b000} + {3'b000, dh, 1'b0};

	// Decision flags
	always_comb begin
		ctl.high         = high_s1;
		ctl.quarter_ok   = quarter_en && (dtr_x10 > ONE_Q) && (dbl_x10 > ONE_Q);
		ctl.half_tie     = dh_x10 < ONE_H;
		ctl.top_brighter = top_s1 > bot_s1;
		ctl.shade_sum    = shade_code({sum_s1 < SUM_T1, sum_s1 < SUM_T3,
		                               sum_s1 < SUM_T7, sum_s1 < SUM_T11});
		ctl.shade_mean   = shade_code({mean_s1 < MEAN_T1, mean_s1 < MEAN_T3,
		                               mean_s1 < MEAN_T7, mean_s1 < MEAN_T11});
	end

	// Valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (en && v_s1) begin
			ctl_s2 <= ctl;
		end
	end

endmodule

/* hdl/bgc_select.sv */
// Stage 3: glyph selection into the output register.
module bgc_select (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             half_en,
	input  logic             v_s2,
	input  bgc_pkg::bgc_s2_t ctl_s2,
	output logic             v_s3,
	output bgc_pkg::glyph_t  glyph_s3
);
	import bgc_pkg::*;

	logic [2:0] cnt;
	glyph_t     half_glyph;
	glyph_t     quarter_glyph;
	glyph_t     glyph;

	// Number of high quadrants
	assign cnt = {2'b00, ctl_s2.high[QD_TL]} + {2'b00, ctl_s2.high[QD_TR]}
	           + {2'b00, ctl_s2.high[QD_BL]} + {2'b00, ctl_s2.high[QD_BR]};

	// Half decision
	always_comb begin
		if (ctl_s2.half_tie) begin
			half_glyph = ctl_s2.shade_sum;
		end else if (ctl_s2.top_brighter) begin
			half_glyph = GLYPH_UPPER;
		end else begin
			half_glyph = GLYPH_LOWER;
		end
	end

	// Quarter decision
	always_comb begin
		case (cnt)
			3'd1: begin
				if (ctl_s2.high[QD_TL]) begin
					quarter_glyph = GLYPH_Q_UL;
				end else if (ctl_s2.high[QD_TR]) begin
					quarter_glyph = GLYPH_Q_UR;
				end else if (ctl_s2.high[QD_BL]) begin
					quarter_glyph = GLYPH_Q_LL;
				end else begin
					quarter_glyph = GLYPH_Q_LR;
				end
			end
			3'd2: begin
				// vertical pairs make left/right, others go to the half test
				if (ctl_s2.high[QD_TL] && ctl_s2.high[QD_BL]) begin
					quarter_glyph = GLYPH_LEFT;
				end else if (ctl_s2.high[QD_TR] && ctl_s2.high[QD_BR]) begin
					quarter_glyph = GLYPH_RIGHT;
				end else begin
					quarter_glyph = half_glyph;
				end
			end
			3'd3: begin
				// quarter opposite the single low quadrant
				if (!ctl_s2.high[QD_TL]) begin
					quarter_glyph = GLYPH_Q_LR;
				end else if (!ctl_s2.high[QD_TR]) begin
					quarter_glyph = GLYPH_Q_LL;
				end else if (!ctl_s2.high[QD_BL]) begin
					quarter_glyph = GLYPH_Q_UR;
				end else begin
					quarter_glyph = GLYPH_Q_UL;
				end
			end
			default: begin
				// none or all high
				quarter_glyph = ctl_s2.shade_sum;
			end
		endcase
	end

	// Mode priority
	always_comb begin
		if (ctl_s2.quarter_ok) begin
			glyph = quarter_glyph;
		end else if (half_en) begin
			glyph = half_glyph;
		end else begin
			glyph = ctl_s2.shade_mean;
		end
	end

	// Valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (en && v_s2) begin
			glyph_s3 <= glyph;
		end
	end

endmodule

/* hdl/block_glyph_classifier_top.sv */
// An accepted input beat passes stage 1, 2 and 3 registers to reach the output.
// Throughput: one cell per cycle; the three-stage pipeline stalls as a whole
// only while a result is held on the output and not taken.
// Reset: arst_n clears all stage valid bits and sets both mode enables to 1.
// Configuration writes are taken in every cycle and complete at once.
// Top level of the block glyph classifier.
module block_glyph_classifier_top #(
	parameter int LUM_BITS = 12
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bgc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic                             cfg_data,
	// input cells
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [LUM_BITS-1:0]              lum_top_left,
	input  logic [LUM_BITS-1:0]              lum_top_right,
	input  logic [LUM_BITS-1:0]              lum_bottom_left,
	input  logic [LUM_BITS-1:0]              lum_bottom_right,
	input  logic [LUM_BITS-1:0]              lum_cell_mean,
	// results
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [3:0]                       glyph_code
);
	import bgc_pkg::*;

	logic                quarter_en_q;
	logic                half_en_q;
	logic                advance;
	logic                v_s1;
	logic [LUM_BITS-1:0] dtr_s1;
	logic [LUM_BITS-1:0] dbl_s1;
	logic [LUM_BITS:0]   top_s1;
	logic [LUM_BITS:0]   bot_s1;
	logic [LUM_BITS+1:0] sum_s1;
	logic [3:0]          high_s1;
	logic [LUM_BITS-1:0] mean_s1;
	logic                v_s2;
	bgc_s2_t             ctl_s2;
	glyph_t              glyph_s3;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quarter_en_q <= 1'b1;
			half_en_q    <= 1'b1;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_QUARTER_EN) begin
				quarter_en_q <= cfg_data;
			end
			if (cfg_index == CFG_HALF_EN) begin
				half_en_q <= cfg_data;
			end
		end
	end

	// Pipeline moves whenever the output slot is free or being taken
	assign advance  = !out_valid || out_ready;
	assign in_ready = advance;

	bgc_front #(
		.LUM_BITS(LUM_BITS)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (advance),
		.in_valid        (in_valid),
		.lum_top_left    (lum_top_left),
		.lum_top_right   (lum_top_right),
		.lum_bottom_left (lum_bottom_left),
		.lum_bottom_right(lum_bottom_right),
		.lum_cell_mean   (lum_cell_mean),
		.v_s1            (v_s1),
		.dtr_s1          (dtr_s1),
		.dbl_s1          (dbl_s1),
		.top_s1          (top_s1),
		.bot_s1          (bot_s1),
		.sum_s1          (sum_s1),
		.high_s1         (high_s1),
		.mean_s1         (mean_s1)
	);

	bgc_thresh #(
		.LUM_BITS(LUM_BITS)
	) u_thresh (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.quarter_en(quarter_en_q),
		.v_s1      (v_s1),
		.dtr_s1    (dtr_s1),
		.dbl_s1    (dbl_s1),
		.top_s1    (top_s1),
		.bot_s1    (bot_s1),
		.sum_s1    (sum_s1),
		.high_s1   (high_s1),
		.mean_s1   (mean_s1),
		.v_s2      (v_s2),
		.ctl_s2    (ctl_s2)
	);

	bgc_select u_select (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (advance),
		.half_en (half_en_q),
		.v_s2    (v_s2),
		.ctl_s2  (ctl_s2),
		.v_s3    (out_valid),
		.glyph_s3(glyph_s3)
	);

	assign glyph_code = glyph_s3;

	// Accepted beat lands in stage 1
	a_accept_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> v_s1)
		else $error("accepted beat did not enter stage 1");

	// Stalled pipeline keeps its inner valid bits
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> ($stable(v_s1) && $stable(v_s2)))
		else $error("inner stage valid changed during stall");

	// Only defined glyph codes leave the block
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (glyph_code <= GLYPH_RIGHT))
		else $error("glyph code out of range");

	// Stage 2 beat moves to the output when the pipeline advances
	a_s2_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && advance) |=> out_valid)
		else $error("stage 2 beat lost");

endmodule
